@@ rtl/core/ial_pkg.sv @@
// Shared types and constants for the indexed array list.
package ial_pkg;

   localparam int MODE_W  = 3;
   localparam int FIELD_W = 7;
   localparam int WORD_W  = 32;

   localparam logic [FIELD_W-1:0] CAP_RESET = FIELD_W'(64);

   typedef enum logic [MODE_W-1:0] {
      MODE_READ      = 3'd0,
      MODE_INSERT    = 3'd1,
      MODE_APPEND    = 3'd2,
      MODE_OVERWRITE = 3'd3,
      MODE_DEL_INDEX = 3'd4,
      MODE_DEL_VALUE = 3'd5,
      MODE_CLEAR     = 3'd6
   } ial_mode_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_START,
      CMD_SCAN,
      CMD_FINISH
   } ial_cmd_type;

   typedef struct packed {
      logic scan_idle;
      logic op_ok;
   } ial_sts_type;

endpackage

@@ rtl/core/ial_ifs.sv @@
// Channel interfaces: request, response and capacity register write.
interface ial_req_if;
   import ial_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic [FIELD_W-1:0]       position;
   logic signed [WORD_W-1:0] item_value;
   modport source (output valid, mode, position, item_value, input ready);
   modport sink (input valid, mode, position, item_value, output ready);
endinterface

interface ial_rsp_if;
   import ial_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] read_word;
   logic [FIELD_W-1:0]       entry_count;
   logic                     status;
   modport source (output valid, read_word, entry_count, status, input ready);
   modport sink (input valid, read_word, entry_count, status, output ready);
endinterface

interface ial_csr_if;
   import ial_pkg::*;
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] capacity_limit;
   modport source (output valid, capacity_limit, input ready);
   modport sink (input valid, capacity_limit, output ready);
endinterface

@@ rtl/core/indexed_array_list_top.sv @@
// Top level of the indexed array list.
// Ordered list of signed 32-bit words held in a DEPTH-entry memory. One request
// beat carries a mode (read, insert, append, overwrite, delete at index, delete
// by value, clear) and returns exactly one response beat with the word read, the
// count afterwards and a rejected flag. Requests are handled one at a time; each
// operation visits k entries: 1 for a valid read, count - position for insert,
// count - position - 1 for delete at index, count for delete by value, 0 for
// append, overwrite, clear and any rejected request. The entry memory moves one
// entry per cycle through its single read and single write port. The next request
// is taken while a finished response still waits. The capacity register resets
// to 64 and values above DEPTH act as DEPTH; write it only when idle.
module indexed_array_list_top #(
   parameter int DEPTH = 64
) (
   input logic       clock,
   input logic       reset,
   ial_req_if.sink   req_bus,
   ial_rsp_if.source rsp_bus,
   ial_csr_if.sink   csr_bus
);
   import ial_pkg::*;

   ial_cmd_type cmd;
   ial_sts_type sts;

   ial_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .rsp_valid(rsp_bus.valid),
      .rsp_ready(rsp_bus.ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   ial_dp #(
      .DEPTH(DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_mode          (req_bus.mode),
      .req_position      (req_bus.position),
      .req_item_value    (req_bus.item_value),
      .csr_valid         (csr_bus.valid),
      .csr_capacity_limit(csr_bus.capacity_limit),
      .rsp_read_word     (rsp_bus.read_word),
      .rsp_entry_count   (rsp_bus.entry_count),
      .rsp_status        (rsp_bus.status)
   );

   assign csr_bus.ready = 1'b1;

endmodule

@@ rtl/core/ial_ram.sv @@
// Generic RAM, one write port and one registered read port.
module ial_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ial_ctrl.sv @@
// Controller: sequences each operation and owns the channel handshakes.
module ial_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ial_pkg::ial_sts_type sts,
   output ial_pkg::ial_cmd_type cmd
);
   import ial_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = CMD_NONE;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd      = CMD_START;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd = CMD_SCAN;
            if (sts.scan_idle) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd          = CMD_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && rsp_valid_ff && !rsp_ready |=> state_ff == ST_FINISH)
      else $error("finish overran a pending response");
   a_reject_no_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) && !sts.op_ok |=> sts.scan_idle)
      else $error("rejected operation started a scan");
`endif

endmodule

@@ rtl/core/ial_dp.sv @@
// Datapath: entry store, count, capacity, scan pointers and result registers.
module ial_dp #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ial_pkg::ial_cmd_type                cmd,
   output ial_pkg::ial_sts_type                sts,
   input  logic [ial_pkg::MODE_W-1:0]          req_mode,
   input  logic [ial_pkg::FIELD_W-1:0]         req_position,
   input  logic signed [ial_pkg::WORD_W-1:0]   req_item_value,
   input  logic                                csr_valid,
   input  logic [ial_pkg::FIELD_W-1:0]         csr_capacity_limit,
   output logic signed [ial_pkg::WORD_W-1:0]   rsp_read_word,
   output logic [ial_pkg::FIELD_W-1:0]         rsp_entry_count,
   output logic                                rsp_status
);
   import ial_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CmpW = (CW > FIELD_W) ? CW : FIELD_W;

   // control state
   logic [CW-1:0]      count_ff, count_in;
   logic [FIELD_W-1:0] cap_ff, cap_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic               pend_ff, pend_in;

   // operation and scan payload
   ial_mode_type             mode_ff, mode_in;
   logic [FIELD_W-1:0]       pos_ff, pos_in;
   logic signed [WORD_W-1:0] word_ff, word_in;
   logic [CW-1:0]            ptr_ff, ptr_in;
   logic [AW-1:0]            pend_addr_ff, pend_addr_in;
   logic [CW-1:0]            kept_ff, kept_in;
   logic signed [WORD_W-1:0] rd_word_ff, rd_word_in;
   logic signed [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic [FIELD_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                     rsp_status_ff, rsp_status_in;

   logic [CmpW-1:0]   n_ext;
   logic [CmpW-1:0]   tgt;
   logic              op_ok;
   logic              down;
   logic              issue;
   logic              done;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] rd_data;

   always_comb begin
      n_ext = CmpW'(count_ff);
      tgt   = (mode_ff == MODE_APPEND) ? n_ext : CmpW'(pos_ff);
      down  = (mode_ff == MODE_INSERT) || (mode_ff == MODE_APPEND);
      case (mode_ff)
         MODE_READ, MODE_OVERWRITE, MODE_DEL_INDEX: begin
            op_ok = tgt < n_ext;
         end
         MODE_INSERT, MODE_APPEND: begin
            op_ok = (tgt <= n_ext) && (n_ext < CmpW'(cap_ff)) && (n_ext != CmpW'(DEPTH));
         end
         MODE_DEL_VALUE, MODE_CLEAR: begin
            op_ok = 1'b1;
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
   end

   assign issue         = (cmd == CMD_SCAN) && (rem_ff != '0);
   assign done          = (cmd == CMD_SCAN) && pend_ff;
   assign sts.scan_idle = (rem_ff == '0) && !pend_ff;
   assign sts.op_ok     = op_ok;

   // store write port: shift moves during the scan, the new word at finish
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pend_addr_ff;
      wr_data = rd_data;
      if (done) begin
         case (mode_ff)
            MODE_INSERT, MODE_APPEND: begin
               wr_en   = 1'b1;
               wr_addr = AW'(pend_addr_ff + 1'b1);
            end
            MODE_DEL_INDEX: begin
               wr_en   = 1'b1;
               wr_addr = AW'(pend_addr_ff - 1'b1);
            end
            MODE_DEL_VALUE: begin
               wr_en   = (rd_data != word_ff);
               wr_addr = kept_ff[AW-1:0];
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end else if ((cmd == CMD_FINISH) && op_ok &&
                   ((mode_ff == MODE_INSERT) || (mode_ff == MODE_APPEND) ||
                    (mode_ff == MODE_OVERWRITE))) begin
         wr_en   = 1'b1;
         wr_addr = tgt[AW-1:0];
         wr_data = word_ff;
      end
   end

   always_comb begin
      count_in      = count_ff;
      cap_in        = cap_ff;
      rem_in        = rem_ff;
      pend_in       = pend_ff;
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      ptr_in        = ptr_ff;
      pend_addr_in  = pend_addr_ff;
      kept_in       = kept_ff;
      rd_word_in    = rd_word_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (csr_valid) begin
         cap_in = csr_capacity_limit;
      end
      case (cmd)
         CMD_LOAD: begin
            mode_in = ial_mode_type'(req_mode);
            pos_in  = req_position;
            word_in = req_item_value;
         end
         CMD_START: begin
            pend_in = 1'b0;
            kept_in = '0;
            rem_in  = '0;
            case (mode_ff)
               MODE_INSERT, MODE_APPEND: begin
                  ptr_in = CW'(n_ext - 1'b1);
                  rem_in = CW'(n_ext - tgt);
               end
               MODE_DEL_INDEX: begin
                  ptr_in = CW'(tgt + 1'b1);
                  rem_in = CW'(n_ext - tgt - 1'b1);
               end
               MODE_DEL_VALUE: begin
                  ptr_in = '0;
                  rem_in = count_ff;
               end
               MODE_READ: begin
                  ptr_in = CW'(tgt);
                  rem_in = CW'(1'b1);
               end
               default: begin
                  rem_in = '0;
               end
            endcase
            if (!op_ok) begin
               rem_in = '0;
            end
         end
         CMD_SCAN: begin
            pend_in = issue;
            if (issue) begin
               rem_in       = rem_ff - 1'b1;
               ptr_in       = down ? (ptr_ff - 1'b1) : (ptr_ff + 1'b1);
               pend_addr_in = ptr_ff[AW-1:0];
            end
            if (done) begin
               if ((mode_ff == MODE_DEL_VALUE) && (rd_data != word_ff)) begin
                  kept_in = kept_ff + 1'b1;
               end
               if (mode_ff == MODE_READ) begin
                  rd_word_in = rd_data;
               end
            end
         end
         CMD_FINISH: begin
            if (op_ok) begin
               case (mode_ff)
                  MODE_INSERT, MODE_APPEND: count_in = count_ff + 1'b1;
                  MODE_DEL_INDEX:           count_in = count_ff - 1'b1;
                  MODE_DEL_VALUE:           count_in = kept_ff;
                  MODE_CLEAR:               count_in = '0;
                  default:                  count_in = count_ff;
               endcase
            end
            rsp_word_in   = ((mode_ff == MODE_READ) && op_ok) ? rd_word_ff : '0;
            rsp_count_in  = FIELD_W'(count_in);
            rsp_status_in = !op_ok;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
         rem_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
         rem_ff   <= rem_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      ptr_ff        <= ptr_in;
      pend_addr_ff  <= pend_addr_in;
      kept_ff       <= kept_in;
      rd_word_ff    <= rd_word_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   ial_ram #(
      .WIDTH(WORD_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (issue),
      .rd_addr(ptr_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   assign rsp_read_word   = rsp_word_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CmpW'(count_ff) <= CmpW'(DEPTH))
      else $error("entry count above store depth");
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      wr_en && issue |-> wr_addr != ptr_ff[AW-1:0])
      else $error("store read and write hit the same entry");
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_SCAN) && (mode_ff == MODE_DEL_VALUE) |-> kept_ff <= count_ff)
      else $error("compaction ran past the entry count");
`endif

endmodule

@@ tb/ial_list_checker.sv @@
// Checker for the indexed array list: shadows the list, predicts each response beat and compares.
`timescale 1ns / 100ps

module ial_list_checker #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   ial_req_if                          req_bus,
   ial_rsp_if                          rsp_bus,
   ial_csr_if                          csr_bus,
   output int                          fail_count,
   output int                          outstanding,
   output logic [ial_pkg::FIELD_W-1:0] list_size
);
   import ial_pkg::*;

   typedef struct packed {
      logic signed [WORD_W-1:0] read_word;
      logic [FIELD_W-1:0]       entry_count;
      logic                     status;
   } list_result_type;

   logic [WORD_W-1:0] shadow_words [DEPTH];
   int                shadow_count;
   int                shadow_cap;
   list_result_type   pending_results [$];

   function automatic list_result_type apply_list_op(input logic [MODE_W-1:0] op,
                                                     input logic [FIELD_W-1:0] pos,
                                                     input logic [WORD_W-1:0] word);
      list_result_type res;
      int              eff_cap;
      int              at;
      int              kept;
      res.read_word = '0;
      res.status    = 1'b0;
      eff_cap = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
      case (op)
         MODE_READ: begin
            if (pos < shadow_count) res.read_word = shadow_words[pos];
            else res.status = 1'b1;
         end
         MODE_INSERT, MODE_APPEND: begin
            at = (op == MODE_APPEND) ? shadow_count : int'(pos);
            if (at > shadow_count || shadow_count >= eff_cap) begin
               res.status = 1'b1;
            end else begin
               for (int i = shadow_count; i > at; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[at] = word;
               shadow_count++;
            end
         end
         MODE_OVERWRITE: begin
            if (pos < shadow_count) shadow_words[pos] = word;
            else res.status = 1'b1;
         end
         MODE_DEL_INDEX: begin
            if (pos < shadow_count) begin
               for (int i = int'(pos) + 1; i < shadow_count; i++)
                  shadow_words[i-1] = shadow_words[i];
               shadow_count--;
            end else begin
               res.status = 1'b1;
            end
         end
         MODE_DEL_VALUE: begin
            kept = 0;
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_words[i] != word) begin
                  shadow_words[kept] = shadow_words[i];
                  kept++;
               end
            end
            shadow_count = kept;
         end
         MODE_CLEAR: shadow_count = 0;
         default: res.status = 1'b1;
      endcase
      res.entry_count = FIELD_W'(shadow_count);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         shadow_count = 0;
         shadow_cap   = int'(CAP_RESET);
         pending_results.delete();
         outstanding <= 0;
         list_size   <= '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) shadow_cap = int'(csr_bus.capacity_limit);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unrequested beat", rsp_bus.read_word, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.read_word !== want.read_word)
                  report_mismatch("read_word", rsp_bus.read_word, want.read_word);
               if (rsp_bus.entry_count !== want.entry_count)
                  report_mismatch("entry_count", WORD_W'(rsp_bus.entry_count),
                                  WORD_W'(want.entry_count));
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", WORD_W'(rsp_bus.status), WORD_W'(want.status));
            end
         end
         if (req_bus.valid && req_bus.ready)
            pending_results.push_back(apply_list_op(req_bus.mode, req_bus.position,
                                                    req_bus.item_value));
         outstanding <= pending_results.size();
         list_size   <= FIELD_W'(shadow_count);
      end
   end

endmodule

@@ tb/indexed_array_list_top_tb.sv @@
// Testbench top for the indexed array list: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module indexed_array_list_top_tb;
   import ial_pkg::*;

   localparam int DEPTH           = 64;
   localparam int ROUNDS          = 10;
   localparam int ITEMS_PER_ROUND = 102;
   localparam int LONG_STALL      = 300;
   localparam int QUIET_LIMIT     = 4000;

   localparam logic [MODE_W-1:0] MODE_RESERVED = 3'd7;
   localparam logic [WORD_W-1:0] WORD_MAX      = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_MIN      = 32'h8000_0000;
   localparam logic [WORD_W-1:0] WORD_ONES     = 32'hFFFF_FFFF;

   typedef enum {MIX_GROW, MIX_CHURN, MIX_SHRINK} op_mix_type;

   logic clock;
   logic reset;
   logic idle_on;
   int   stall_requests;
   int   quiet_cycles;
   int   fail_count;
   int   outstanding;
   logic [FIELD_W-1:0] list_size;

   ial_req_if req_bus ();
   ial_rsp_if rsp_bus ();
   ial_csr_if csr_bus ();

   indexed_array_list_top #(.DEPTH(DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   ial_list_checker #(.DEPTH(DEPTH)) list_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .list_size   (list_size)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // response side: random back-pressure plus requested long hold-offs
   initial begin
      int stalls_served;
      stalls_served = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_requests != stalls_served) begin
            stalls_served++;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end
         rsp_bus.ready <= !(idle_on && $urandom_range(0, 99) < 37);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("indexed_array_list_top_tb failed");
         $finish;
      end
   end

   function automatic logic [MODE_W-1:0] pick_mode(input op_mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_GROW: begin
            if (r < 45) return MODE_APPEND;
            if (r < 80) return MODE_INSERT;
            if (r < 90) return MODE_READ;
            if (r < 95) return MODE_OVERWRITE;
            if (r < 97) return MODE_DEL_INDEX;
            if (r < 99) return MODE_DEL_VALUE;
            return MODE_RESERVED;
         end
         MIX_SHRINK: begin
            if (r < 35) return MODE_DEL_INDEX;
            if (r < 55) return MODE_DEL_VALUE;
            if (r < 70) return MODE_READ;
            if (r < 80) return MODE_OVERWRITE;
            if (r < 90) return MODE_INSERT;
            if (r < 95) return MODE_APPEND;
            if (r < 98) return MODE_CLEAR;
            return MODE_RESERVED;
         end
         default: begin
            if (r < 22) return MODE_READ;
            if (r < 42) return MODE_INSERT;
            if (r < 57) return MODE_APPEND;
            if (r < 72) return MODE_OVERWRITE;
            if (r < 87) return MODE_DEL_INDEX;
            if (r < 95) return MODE_DEL_VALUE;
            if (r < 98) return MODE_CLEAR;
            return MODE_RESERVED;
         end
      endcase
   endfunction

   function automatic int pick_position(input int n);
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(0, n);
      if (r < 85) return $urandom_range((n == 0) ? 0 : n - 1, n + 1);
      return $urandom_range(0, 127);
   endfunction

   // small pool so delete-by-value finds repeats
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return WORD_ONES;
         1: return '0;
         2: return WORD_MAX;
         3: return WORD_MIN;
         4: return 32'd7;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_req(input logic [MODE_W-1:0] op, input int pos,
                           input logic [WORD_W-1:0] word);
      if (idle_on) begin
         while ($urandom_range(0, 99) < 37) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= op;
      req_bus.position   <= FIELD_W'(pos);
      req_bus.item_value <= word;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input int cap);
      csr_bus.valid          <= 1'b1;
      csr_bus.capacity_limit <= FIELD_W'(cap);
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      int         cap_plan [ROUNDS];
      op_mix_type mix;
      cap_plan = '{127, 0, 64, 1, 64, 2, 65, 64, 0, 33};
      reset                  <= 1'b1;
      idle_on                <= 1'b1;
      stall_requests         <= 0;
      req_bus.valid          <= 1'b0;
      req_bus.mode           <= '0;
      req_bus.position       <= '0;
      req_bus.item_value     <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.capacity_limit <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty list, reserved mode, list built from the word extremes
      send_req(MODE_READ, 0, '0);
      send_req(MODE_DEL_INDEX, 0, '0);
      send_req(MODE_OVERWRITE, 0, 32'd1);
      send_req(MODE_DEL_VALUE, 0, '0);
      send_req(MODE_CLEAR, 0, '0);
      send_req(MODE_RESERVED, 0, '0);
      send_req(MODE_INSERT, 1, 32'd9);
      send_req(MODE_APPEND, 0, WORD_MAX);
      send_req(MODE_APPEND, 0, WORD_MIN);
      send_req(MODE_INSERT, 0, WORD_ONES);
      send_req(MODE_INSERT, 3, '0);
      send_req(MODE_INSERT, 1, WORD_ONES);
      send_req(MODE_INSERT, 127, 32'd5);
      send_req(MODE_READ, 0, '0);
      send_req(MODE_READ, 4, '0);
      send_req(MODE_READ, 5, '0);
      send_req(MODE_READ, 127, '0);
      send_req(MODE_OVERWRITE, 3, 32'h5555_5555);
      send_req(MODE_OVERWRITE, 5, 32'hAAAA_AAAA);
      send_req(MODE_DEL_INDEX, 4, '0);
      send_req(MODE_DEL_INDEX, 0, '0);
      send_req(MODE_DEL_VALUE, 0, 32'h1234_5678);
      send_req(MODE_APPEND, 0, WORD_ONES);
      send_req(MODE_DEL_VALUE, 0, WORD_ONES);
      send_req(MODE_READ, 1, '0);

      for (int round = 0; round < ROUNDS; round++) begin
         wait_for_results();
         write_capacity((round == 8) ? $urandom_range(0, 127) : cap_plan[round]);
         idle_on <= (round != 4);
         if (round == 7) stall_requests <= stall_requests + 1;
         case (round)
            2, 4:    mix = MIX_GROW;
            1, 3, 9: mix = MIX_SHRINK;
            default: mix = MIX_CHURN;
         endcase
         for (int n = 0; n < ITEMS_PER_ROUND; n++)
            send_req(pick_mode(mix), pick_position(int'(list_size)), pick_word());
      end

      wait_for_results();
      repeat (DEPTH + 10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("indexed_array_list_top_tb passed");
      end else begin
         $display("indexed_array_list_top_tb failed");
      end
      $finish;
   end

endmodule
